/* rtl/core/html_byte_tokenizer_unit_assert.svh */
// Assertion macros for the tokenizer RTL; hbt_back includes them.
`ifndef HTML_BYTE_TOKENIZER_UNIT_ASSERT_SVH
`define HTML_BYTE_TOKENIZER_UNIT_ASSERT_SVH

// A condition that holds at every clock edge outside reset.
`define HBT_ASSERT_ALWAYS(lbl, clk_s, rst_s, cond) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (cond)) \
        else $error("tokenizer assertion failed");

// A condition that, once seen, implies another one at the next clock edge.
`define HBT_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error("tokenizer assertion failed");

`endif

/* rtl/core/hbt_pkg.sv */
// Shared types and token codes of the HTML byte tokenizer.
package hbt_pkg;

    localparam logic [2:0] KIND_TEXT   = 3'd0;
    localparam logic [2:0] KIND_STAG   = 3'd1;
    localparam logic [2:0] KIND_ETAG   = 3'd2;
    localparam logic [2:0] KIND_ANAME  = 3'd3;
    localparam logic [2:0] KIND_AVALUE = 3'd4;
    localparam logic [2:0] KIND_CMT    = 3'd5;
    localparam logic [2:0] KIND_SGML   = 3'd6;
    localparam logic [2:0] KIND_EOF    = 3'd7;

    localparam int unsigned MAX_RES = 6;
    localparam logic [2:0] MAX_RES_CNT = 3'(MAX_RES);

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_stream;
    } item_t;

    typedef struct packed {
        logic [2:0] token_kind;
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       token_end;
        logic       text_not_blank;
        logic       text_has_newline;
        logic       unterminated;
        logic       last_of_run;
    } result_t;

    // All results caused by one input transaction.
    typedef struct packed {
        result_t [MAX_RES-1:0] res;
        logic    [2:0]         cnt;
    } bundle_t;

endpackage

/* rtl/core/hbt_front.sv */
// Front part: parse state machine that turns one byte into a bundle of results.
module hbt_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  logic            q_full,
    input  hbt_pkg::item_t  item,
    output logic            wr_en,
    output hbt_pkg::bundle_t wr_data
);
    import hbt_pkg::*;

    typedef enum logic [13:0] {
        M_TEXT    = 14'b00000000000001,
        M_STAG    = 14'b00000000000010,
        M_ASKIP   = 14'b00000000000100,
        M_ANAME   = 14'b00000000001000,
        M_AFTER   = 14'b00000000010000,
        M_VPRE    = 14'b00000000100000,
        M_VQUOTE  = 14'b00000001000000,
        M_VBARE   = 14'b00000010000000,
        M_ETAG    = 14'b00000100000000,
        M_ETAIL   = 14'b00001000000000,
        M_ETAILQ  = 14'b00010000000000,
        M_COMMENT = 14'b00100000000000,
        M_SGML    = 14'b01000000000000,
        M_SGMLQ   = 14'b10000000000000
    } mode_t;

    typedef struct packed {
        mode_t      mode;
        logic [1:0] phase;
        logic [7:0] la1;
        logic [1:0] la_cnt;
        logic [7:0] quote;
        logic       nb;
        logic       nl;
        logic       open;
    } pstate_t;

    typedef struct packed {
        pstate_t s;
        bundle_t r;
    } ctx_t;

    localparam logic [7:0] CH_LT   = 8'h3c;
    localparam logic [7:0] CH_BANG = 8'h21;
    localparam logic [7:0] CH_DASH = 8'h2d;
    localparam logic [7:0] CH_GT   = 8'h3e;
    localparam logic [7:0] CH_QM   = 8'h3f;
    localparam logic [7:0] CH_SL   = 8'h2f;
    localparam logic [7:0] CH_EQ   = 8'h3d;

    localparam pstate_t RESET_STATE = '{mode: M_TEXT, phase: 2'd0, la1: 8'd0, la_cnt: 2'd0,
                                        quote: 8'd0, nb: 1'b0, nl: 1'b0, open: 1'b0};

    function automatic logic is_blank(logic [7:0] b);
        return (b >= 8'h09 && b <= 8'h0d) || b == 8'h20;
    endfunction

    function automatic logic is_alpha(logic [7:0] b);
        return (b >= 8'h41 && b <= 8'h5a) || (b >= 8'h61 && b <= 8'h7a);
    endfunction

    function automatic logic is_name(logic [7:0] b);
        return is_alpha(b) || (b >= 8'h30 && b <= 8'h39) || b == 8'h2e || b == CH_DASH
            || b == 8'h3a;
    endfunction

    function automatic logic is_quote(logic [7:0] b);
        return b == 8'h22 || b == 8'h27;
    endfunction

    function automatic logic [7:0] upcase(logic [7:0] b);
        return (b >= 8'h61 && b <= 8'h7a) ? b - 8'd32 : b;
    endfunction

    function automatic ctx_t put(ctx_t c, logic [2:0] kind, logic [7:0] b, logic valid,
                                 logic fin, logic nb, logic nl, logic unt);
        result_t o;
        o = '{token_kind: kind, data_byte: b, byte_valid: valid, token_end: fin,
              text_not_blank: nb, text_has_newline: nl, unterminated: unt, last_of_run: 1'b0};
        if (c.r.cnt < MAX_RES_CNT)
        begin
            c.r.res[c.r.cnt] = o;
            c.r.cnt = c.r.cnt + 3'd1;
        end
        return c;
    endfunction

    function automatic ctx_t emit_byte(ctx_t c, logic [2:0] kind, logic [7:0] b);
        c = put(c, kind, b, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
        c.s.open = 1'b1;
        return c;
    endfunction

    function automatic ctx_t emit_text(ctx_t c, logic [7:0] b);
        c = emit_byte(c, KIND_TEXT, b);
        if (!is_blank(b))
            c.s.nb = 1'b1;
        if (b == 8'h0d || b == 8'h0a)
            c.s.nl = 1'b1;
        return c;
    endfunction

    function automatic ctx_t close_tok(ctx_t c, logic [2:0] kind, logic unt);
        if (c.s.open)
        begin
            if (kind == KIND_TEXT)
            begin
                c = put(c, KIND_TEXT, 8'd0, 1'b0, 1'b1, c.s.nb, c.s.nl, 1'b0);
                c.s.nb = 1'b0;
                c.s.nl = 1'b0;
            end
            else
            begin
                c = put(c, kind, 8'd0, 1'b0, 1'b1, 1'b0, 1'b0, unt);
            end
            c.s.open = 1'b0;
        end
        return c;
    endfunction

    function automatic ctx_t enter(ctx_t c, mode_t m);
        c = close_tok(c, KIND_TEXT, 1'b0);
        c.s.la_cnt = 2'd0;
        c.s.mode = m;
        c.s.open = 1'b1;
        return c;
    endfunction

    function automatic ctx_t in_text(ctx_t c, logic [7:0] b, output logic cons);
        cons = 1'b0;
        case (c.s.la_cnt)
            2'd0:
            begin
                if (b == CH_LT)
                    c.s.la_cnt = 2'd1;
                else
                    c = emit_text(c, b);
                cons = 1'b1;
            end
            2'd1:
            begin
                if (b == CH_BANG || b == CH_SL)
                begin
                    c.s.la1 = b;
                    c.s.la_cnt = 2'd2;
                    cons = 1'b1;
                end
                else if (b == CH_QM)
                begin
                    c = enter(c, M_SGML);
                    c = emit_byte(c, KIND_SGML, b);
                    cons = 1'b1;
                end
                else if (is_alpha(b))
                begin
                    c = enter(c, M_STAG);
                end
                else
                begin
                    c = emit_text(c, CH_LT);
                    c.s.la_cnt = 2'd0;
                end
            end
            2'd2:
            begin
                if (c.s.la1 == CH_BANG)
                begin
                    if (b == CH_DASH)
                    begin
                        c.s.la_cnt = 2'd3;
                        cons = 1'b1;
                    end
                    else
                    begin
                        c = enter(c, M_SGML);
                        c = emit_byte(c, KIND_SGML, CH_BANG);
                    end
                end
                else if (is_alpha(b))
                begin
                    c = enter(c, M_ETAG);
                end
                else
                begin
                    c = emit_text(c, CH_LT);
                    c = emit_text(c, CH_SL);
                    c.s.la_cnt = 2'd0;
                end
            end
            default:
            begin
                if (b == CH_DASH)
                begin
                    c = enter(c, M_COMMENT);
                    c.s.phase = 2'd0;
                    cons = 1'b1;
                end
                else
                begin
                    c = enter(c, M_SGML);
                    c = emit_byte(c, KIND_SGML, CH_BANG);
                    c = emit_byte(c, KIND_SGML, CH_DASH);
                end
            end
        endcase
        return c;
    endfunction

    function automatic ctx_t handle(ctx_t c, logic [7:0] b, output logic cons);
        logic [2:0] kind;
        logic       tc;
        cons = 1'b1;
        kind = KIND_STAG;
        case (c.s.mode)
            M_STAG, M_ANAME, M_ETAG:
            begin
                kind = (c.s.mode == M_STAG) ? KIND_STAG :
                       (c.s.mode == M_ANAME) ? KIND_ANAME : KIND_ETAG;
                if (is_name(b))
                begin
                    c = emit_byte(c, kind, upcase(b));
                end
                else
                begin
                    c = close_tok(c, kind, 1'b0);
                    c.s.mode = (c.s.mode == M_ETAG) ? M_ETAIL :
                               (c.s.mode == M_ANAME) ? M_AFTER : M_ASKIP;
                    cons = 1'b0;
                end
            end
            M_ASKIP:
            begin
                if (b == CH_GT)
                    c.s.mode = M_TEXT;
                else if (is_alpha(b))
                begin
                    c.s.mode = M_ANAME;
                    c.s.open = 1'b1;
                    cons = 1'b0;
                end
            end
            M_AFTER:
            begin
                if (b == CH_EQ)
                begin
                    c.s.mode = M_VPRE;
                    c.s.open = 1'b1;
                end
                else if (!is_blank(b))
                begin
                    c.s.mode = M_ASKIP;
                    cons = 1'b0;
                end
            end
            M_VPRE:
            begin
                if (is_quote(b))
                begin
                    c.s.quote = b;
                    c.s.mode = M_VQUOTE;
                end
                else if (!is_blank(b))
                begin
                    c.s.mode = M_VBARE;
                    cons = 1'b0;
                end
            end
            M_VQUOTE:
            begin
                if (b == c.s.quote)
                begin
                    c = close_tok(c, KIND_AVALUE, 1'b0);
                    c.s.mode = M_ASKIP;
                end
                else
                    c = emit_byte(c, KIND_AVALUE, b);
            end
            M_VBARE:
            begin
                if (b == CH_GT || is_blank(b))
                begin
                    c = close_tok(c, KIND_AVALUE, 1'b0);
                    c.s.mode = M_ASKIP;
                    cons = is_blank(b);
                end
                else
                    c = emit_byte(c, KIND_AVALUE, b);
            end
            M_ETAIL:
            begin
                if (b == CH_GT)
                    c.s.mode = M_TEXT;
                else if (is_quote(b))
                begin
                    c.s.quote = b;
                    c.s.mode = M_ETAILQ;
                end
            end
            M_ETAILQ:
            begin
                if (b == c.s.quote)
                    c.s.mode = M_ETAIL;
            end
            M_COMMENT:
            begin
                if (c.s.phase == 2'd0)
                begin
                    if (b == CH_DASH)
                        c.s.phase = 2'd1;
                    else
                        c = emit_byte(c, KIND_CMT, b);
                end
                else if (c.s.phase == 2'd1)
                begin
                    if (b == CH_DASH)
                        c.s.phase = 2'd2;
                    else
                    begin
                        c = emit_byte(c, KIND_CMT, CH_DASH);
                        c = emit_byte(c, KIND_CMT, b);
                        c.s.phase = 2'd0;
                    end
                end
                else if (b == CH_GT)
                begin
                    c = close_tok(c, KIND_CMT, 1'b0);
                    c.s.phase = 2'd0;
                    c.s.mode = M_TEXT;
                end
            end
            M_SGML:
            begin
                if (b == CH_GT)
                begin
                    c = close_tok(c, KIND_SGML, 1'b0);
                    c.s.mode = M_TEXT;
                end
                else
                begin
                    c = emit_byte(c, KIND_SGML, b);
                    if (is_quote(b))
                    begin
                        c.s.quote = b;
                        c.s.mode = M_SGMLQ;
                    end
                end
            end
            M_SGMLQ:
            begin
                c = emit_byte(c, KIND_SGML, b);
                if (b == c.s.quote)
                    c.s.mode = M_SGML;
            end
            default:
            begin
                c.s.mode = M_TEXT;
                c = in_text(c, b, tc);
                cons = tc;
            end
        endcase
        return c;
    endfunction

    function automatic ctx_t finish(ctx_t c);
        logic in_construct;
        logic three;
        in_construct = 1'b1;
        case (c.s.mode)
            M_STAG:             c = close_tok(c, KIND_STAG, 1'b1);
            M_ANAME:            c = close_tok(c, KIND_ANAME, 1'b1);
            M_ETAG:             c = close_tok(c, KIND_ETAG, 1'b1);
            M_VPRE, M_VQUOTE,
            M_VBARE:            c = close_tok(c, KIND_AVALUE, 1'b1);
            M_COMMENT:          c = close_tok(c, KIND_CMT, 1'b1);
            M_SGML, M_SGMLQ:    c = close_tok(c, KIND_SGML, 1'b1);
            M_ASKIP, M_AFTER,
            M_ETAIL, M_ETAILQ:  in_construct = 1'b1;
            default:
            begin
                in_construct = 1'b0;
                if (c.s.la_cnt >= 2'd2 && c.s.la1 == CH_BANG)
                begin
                    three = (c.s.la_cnt == 2'd3);
                    c = enter(c, M_SGML);
                    c = emit_byte(c, KIND_SGML, CH_BANG);
                    if (three)
                        c = emit_byte(c, KIND_SGML, CH_DASH);
                    c = close_tok(c, KIND_SGML, 1'b1);
                    in_construct = 1'b1;
                end
                else
                begin
                    if (c.s.la_cnt >= 2'd1)
                        c = emit_text(c, CH_LT);
                    if (c.s.la_cnt >= 2'd2)
                        c = emit_text(c, CH_SL);
                    c = close_tok(c, KIND_TEXT, 1'b0);
                end
            end
        endcase
        c = put(c, KIND_EOF, 8'd0, 1'b0, 1'b1, 1'b0, 1'b0, in_construct);
        c.s = RESET_STATE;
        return c;
    endfunction

    pstate_t state_reg;
    pstate_t state_next;
    ctx_t    ctx;
    logic    accept;

    assign accept = push && !q_full;

    // A byte is handled at most three times: a name or value ends, the
    // following mode hands the byte on once more, and the last mode keeps it.
    always_comb
    begin
        logic cons;
        logic done;
        ctx.s = state_reg;
        ctx.r = '0;
        done  = 1'b0;
        cons  = 1'b0;
        if (item.end_of_stream)
            ctx = finish(ctx);
        else
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (!done)
                begin
                    ctx = handle(ctx, item.in_byte, cons);
                    done = cons;
                end
            end
        end
        state_next = ctx.s;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= RESET_STATE;
        else if (accept)
            state_reg <= state_next;
    end

    assign wr_en   = accept && (ctx.r.cnt != 3'd0);
    assign wr_data = ctx.r;

endmodule

/* rtl/core/hbt_queue.sv */
// Two-entry bundle queue between the parser and the result serializer.
module hbt_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  hbt_pkg::bundle_t wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic             q_empty,
    output hbt_pkg::bundle_t rd_data
);
    import hbt_pkg::*;

    bundle_t    mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       do_wr;
    logic       do_rd;

    assign full    = (count_reg == 2'd2);
    assign q_empty = (count_reg == 2'd0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !q_empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_wr && !do_rd)
            count_next = count_reg + 2'd1;
        else if (do_rd && !do_wr)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_wr)
                wr_ptr_reg <= !wr_ptr_reg;
            if (do_rd)
                rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

/* rtl/core/hbt_back.sv */
// Back part: hands out the results of each bundle one transaction at a time.
module hbt_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_empty,
    input  hbt_pkg::bundle_t  rd_data,
    output logic              rd_en,
    input  logic              pop,
    output logic              empty,
    output hbt_pkg::result_t  result
);
    import hbt_pkg::*;

`include "html_byte_tokenizer_unit_assert.svh"

    bundle_t    cur_reg;
    logic [2:0] idx_reg;
    logic       valid_reg;
    logic       is_last;
    logic       load;

    assign is_last = (idx_reg == cur_reg.cnt - 3'd1);
    assign load    = !valid_reg || (pop && is_last);
    assign rd_en   = load && !q_empty;
    assign empty   = !valid_reg;

    always_comb
    begin
        result = cur_reg.res[idx_reg];
        result.last_of_run = is_last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= 3'd0;
        end
        else if (load)
        begin
            valid_reg <= !q_empty;
            idx_reg   <= 3'd0;
        end
        else if (pop)
        begin
            idx_reg <= idx_reg + 3'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
            cur_reg <= rd_data;
    end

    `HBT_ASSERT_ALWAYS(a_cnt_nonzero, clk, rst_n, !valid_reg || cur_reg.cnt != 3'd0)
    `HBT_ASSERT_ALWAYS(a_idx_in_range, clk, rst_n, !valid_reg || idx_reg < cur_reg.cnt)
    `HBT_ASSERT_NEXT(a_hold_on_stall, clk, rst_n, valid_reg && !pop,
                     valid_reg && $stable(idx_reg))

endmodule

/* rtl/core/html_byte_tokenizer_unit.sv */
// Top level of the HTML byte tokenizer.
// Usage:
// The input channel takes one HTML byte per transaction (push/full); an item with
// end_of_stream set closes any open construct, yields an eof result and returns
// the parser to its reset state for the next stream.
// The result channel is a queue read port (empty/pop): the oldest result sits on
// result while empty is low and leaves on a cycle with pop high.
// Each input transaction causes zero to six results; last_of_run marks the final
// one of a run.
// A result reaches the outputs through the bundle queue: the edge that accepts its
// input writes the bundle there, and the output register loads it from the queue
// once that register is free.
// Throughput: one input byte per cycle while pop is held high and each byte causes
// at most one result; a byte with k results holds the output for k pops, set by
// the serializer that hands out one result per cycle while pop is high.
// The two-entry bundle queue lets the parser keep accepting while the reader
// stalls; full rises once both queue entries are occupied.
// Reset puts the parser in text mode with no token open and empties the queue.
module html_byte_tokenizer_unit (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  hbt_pkg::item_t   item,
    input  logic             pop,
    output logic             empty,
    output hbt_pkg::result_t result
);
    import hbt_pkg::*;

    logic    wr_en;
    bundle_t wr_data;
    logic    rd_en;
    logic    q_empty;
    bundle_t rd_data;

    hbt_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .q_full  (full),
        .item    (item),
        .wr_en   (wr_en),
        .wr_data (wr_data)
    );

    hbt_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_data (wr_data),
        .full    (full),
        .rd_en   (rd_en),
        .q_empty (q_empty),
        .rd_data (rd_data)
    );

    hbt_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .rd_data (rd_data),
        .rd_en   (rd_en),
        .pop     (pop),
        .empty   (empty),
        .result  (result)
    );

endmodule
